[hdl/mcdec_pkg.sv]
package mcdec_pkg;

	localparam int ROW_W    = 8;
	localparam int CHK_W    = 5;
	localparam int HAM_W    = 4;
	localparam int MAX_ROWS = 4;
	localparam int DATA_W   = MAX_ROWS * ROW_W;
	localparam int RCHK_W   = MAX_ROWS * CHK_W;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// Hamming column patterns, bit h is row h of the check matrix
	localparam logic [HAM_W-1:0] HCOL [ROW_W] = '{
		4'h3, 4'h5, 4'h6, 4'h7, 4'h9, 4'hA, 4'hB, 4'hC
	};

	// What one correction lane found in its row
	typedef struct packed {
		logic             dbl;
		logic             fixed;
		logic [ROW_W-1:0] flip;
	} fix_res_t;

endpackage

[hdl/mcdec_lane.sv]
module mcdec_lane
	import mcdec_pkg::*;
(
	input  logic [ROW_W-1:0] row_bits,
	input  logic [CHK_W-1:0] stored,
	input  logic             decode,
	output logic [CHK_W-1:0] chk
);

	logic [HAM_W-1:0] syn;
	logic             par;

	always_comb begin
		syn = '0;
		par = 1'b0;
		for (int c = 0; c < ROW_W; c++) begin
			if (row_bits[c]) begin
				syn = syn ^ HCOL[c];
				par = ~par;
			end
		end
		chk = {par, syn} ^ (decode ? stored : '0);
	end

endmodule

[hdl/mcdec_fix.sv]
module mcdec_fix
	import mcdec_pkg::*;
(
	input  logic [CHK_W-1:0] chk,
	input  logic [ROW_W-1:0] col_syn,
	input  logic             decode,
	output fix_res_t         res
);

	logic [HAM_W-1:0] syn;

	assign syn = chk[HAM_W-1:0];

	// Take the first column pair, ascending, whose patterns combine to the syndrome
	always_comb begin
		logic found;
		found     = 1'b0;
		res.dbl   = decode && (syn != '0) && !chk[CHK_W-1];
		res.flip  = '0;
		for (int a = 0; a < ROW_W; a++) begin
			for (int b = a + 1; b < ROW_W; b++) begin
				if (res.dbl && !found && col_syn[a] && col_syn[b]
					&& ((HCOL[a] ^ HCOL[b]) == syn)) begin
					found     = 1'b1;
					res.flip[a] = 1'b1;
					res.flip[b] = 1'b1;
				end
			end
		end
		res.fixed = found;
	end

endmodule

[hdl/matrix_code_double_error_corrector.sv]
// Matrix-code ECC for a 32-bit word of 8-bit rows: each row carries four Hamming
// checks plus a row parity bit, and each column carries a parity bit over all rows.
// A transaction is accepted on every clock edge where start is high; busy is always
// low, so a new word may follow in every cycle. The result passes the stage one and
// stage two registers after acceptance and is valid for exactly one cycle while done
// is high; the receiver cannot stall it, so capture it then. Throughput is one word
// per cycle: stage one runs the per-row check lanes and merges the column parity,
// stage two runs the per-row pair-search correction lanes. Encode (opcode 0) returns
// the data with its row checks and column parity. Decode (opcode 1) returns row and
// column syndromes and flips, in each row flagged as a double error, the first column
// pair that explains its syndrome; single errors are reported through the syndromes
// but not corrected. DATA_ROWS sets how many rows are covered, at most the four rows
// of the 32-bit word; rows not covered pass through with zero checks.
module matrix_code_double_error_corrector
	import mcdec_pkg::*;
#(
	parameter int DATA_ROWS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [DATA_W-1:0] data_in,
	input  logic [RCHK_W-1:0] row_checks_in,
	input  logic [ROW_W-1:0]  col_parity_in,
	output logic              done,
	output logic [DATA_W-1:0] data_out,
	output logic [RCHK_W-1:0] row_checks_out,
	output logic [ROW_W-1:0]  col_parity_out,
	output logic [MAX_ROWS-1:0] double_rows,
	output logic [MAX_ROWS-1:0] fixed_rows
);

	// Rows past the word carry nothing, so only the rows inside it get a lane
	localparam int LANES = (DATA_ROWS > MAX_ROWS) ? MAX_ROWS : DATA_ROWS;

	logic              accept;
	logic              decode_in;
	logic [CHK_W-1:0]  chk_c [LANES];
	logic [ROW_W-1:0]  colp_c;

	logic              vld_s1;
	logic              dec_s1;
	logic [DATA_W-1:0] data_s1;
	logic [CHK_W-1:0]  chk_s1 [LANES];
	logic [ROW_W-1:0]  colp_s1;

	fix_res_t          res_c [LANES];
	logic [DATA_W-1:0] data_fix_c;
	logic [RCHK_W-1:0] rchk_c;
	logic [MAX_ROWS-1:0] dbl_c;
	logic [MAX_ROWS-1:0] fix_c;

	// No stall anywhere in the pipe: always ready
	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign decode_in = (opcode == OP_DECODE);

	// Stage one: one check lane per row
	for (genvar r = 0; r < LANES; r++) begin : g_chk
		mcdec_lane u_lane (
			.row_bits (data_in[r*ROW_W +: ROW_W]),
			.stored   (row_checks_in[r*CHK_W +: CHK_W]),
			.decode   (decode_in),
			.chk      (chk_c[r])
		);
	end

	// Merge: column parity over the covered rows, folded with the stored parity on decode
	always_comb begin
		colp_c = decode_in ? col_parity_in : '0;
		for (int r = 0; r < LANES; r++) begin
			colp_c = colp_c ^ data_in[r*ROW_W +: ROW_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Payload of stage one: advance with every accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1  <= decode_in;
			data_s1 <= data_in;
			colp_s1 <= colp_c;
			for (int r = 0; r < LANES; r++) begin
				chk_s1[r] <= chk_c[r];
			end
		end
	end

	// Stage two: one correction lane per row, all looking at the same column syndrome
	for (genvar r = 0; r < LANES; r++) begin : g_fix
		mcdec_fix u_fix (
			.chk     (chk_s1[r]),
			.col_syn (colp_s1),
			.decode  (dec_s1),
			.res     (res_c[r])
		);
	end

	// Assemble the result word; rows without a lane pass through with zero flags
	always_comb begin
		data_fix_c = data_s1;
		rchk_c     = '0;
		dbl_c      = '0;
		fix_c      = '0;
		for (int r = 0; r < LANES; r++) begin
			data_fix_c[r*ROW_W +: ROW_W] = data_s1[r*ROW_W +: ROW_W] ^ res_c[r].flip;
			rchk_c[r*CHK_W +: CHK_W]     = chk_s1[r];
			dbl_c[r]                     = res_c[r].dbl;
			fix_c[r]                     = res_c[r].fixed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	// Result registers: hold the last result, done marks the one cycle it counts
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			data_out       <= data_fix_c;
			row_checks_out <= rchk_c;
			col_parity_out <= colp_s1;
			double_rows    <= dbl_c;
			fixed_rows     <= fix_c;
		end
	end

endmodule

[hdl/mcdec_checker.sv]
module mcdec_checker
	import mcdec_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                opcode,
	input logic [DATA_W-1:0]   data_in,
	input logic                done,
	input logic [DATA_W-1:0]   data_out,
	input logic [MAX_ROWS-1:0] double_rows,
	input logic [MAX_ROWS-1:0] fixed_rows
);

	// Every accepted transaction yields a result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction produced no result");

	// No result without a transaction behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted transaction");

	// A row is only corrected when it was flagged as a double error
	a_fix_in_dbl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((fixed_rows & ~double_rows) == '0))
		else $error("row corrected without double-error flag");

	// Encode leaves the data alone and flags nothing
	a_encode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(opcode == OP_ENCODE, 2))
		|-> (double_rows == '0 && fixed_rows == '0 && data_out == $past(data_in, 2)))
		else $error("encode result altered data or raised flags");

endmodule

bind matrix_code_double_error_corrector mcdec_checker u_mcdec_checker (.*);

[verif/testbench.sv]
module testbench;
	import mcdec_pkg::*;

	// Cover the full 32-bit word with four 8-bit rows
	localparam int ROWS     = 4;
	localparam int PERIOD   = 12;
	// Idle tail that drain adds past the two-stage pipeline once nothing is owed
	localparam int TAIL     = 8;
	localparam int N_RANDOM = 1750;

	// Check matrix rows as column masks: bit c of row h is entry (h, c)
	localparam logic [ROW_W-1:0] HROW0 = 8'h5B;
	localparam logic [ROW_W-1:0] HROW1 = 8'h6D;
	localparam logic [ROW_W-1:0] HROW2 = 8'h8E;
	localparam logic [ROW_W-1:0] HROW3 = 8'hF0;

	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [RCHK_W-1:0]   checks;
		logic [ROW_W-1:0]    col_syn;
		logic [MAX_ROWS-1:0] dbl;
		logic [MAX_ROWS-1:0] fixed;
	} ecc_word_t;

	// Hold the words the block owes us, oldest first, and compute each one
	// from the accepted transaction.
	class ecc_ledger;
		ecc_word_t awaited_words[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function logic [HAM_W-1:0] ham_col(int c);
			return {HROW3[c], HROW2[c], HROW1[c], HROW0[c]};
		endfunction

		// Row parity on top, then the four Hamming checks
		function logic [CHK_W-1:0] row_check_bits(logic [ROW_W-1:0] rb);
			return {^rb, ^(rb & HROW3), ^(rb & HROW2), ^(rb & HROW1), ^(rb & HROW0)};
		endfunction

		function ecc_word_t correct_word(op_t op, logic [DATA_W-1:0] d,
				logic [RCHK_W-1:0] rin, logic [ROW_W-1:0] cin);
			ecc_word_t        res;
			logic [CHK_W-1:0] ck;
			logic [ROW_W-1:0] rb;
			bit               found;
			res = '0;
			res.data = d;
			for (int r = 0; r < ROWS; r++) begin
				rb = d[r*ROW_W +: ROW_W];
				ck = row_check_bits(rb);
				if (op == OP_DECODE)
					ck ^= rin[r*CHK_W +: CHK_W];
				res.checks[r*CHK_W +: CHK_W] = ck;
				res.col_syn ^= rb;
			end
			if (op == OP_DECODE) begin
				res.col_syn ^= cin;
				for (int r = 0; r < ROWS; r++) begin
					ck = res.checks[r*CHK_W +: CHK_W];
					if (ck[HAM_W-1:0] != '0 && !ck[HAM_W]) begin
						res.dbl[r] = 1'b1;
						found = 0;
						// Take the first column pair, ascending, that explains the syndrome
						for (int a = 0; a < ROW_W; a++)
							for (int b = a + 1; b < ROW_W; b++)
								if (!found && res.col_syn[a] && res.col_syn[b] &&
										(ham_col(a) ^ ham_col(b)) == ck[HAM_W-1:0]) begin
									res.data[r*ROW_W + a] ^= 1'b1;
									res.data[r*ROW_W + b] ^= 1'b1;
									res.fixed[r] = 1'b1;
									found = 1;
								end
					end
				end
			end
			return res;
		endfunction

		function void note_transaction(op_t op, logic [DATA_W-1:0] d,
				logic [RCHK_W-1:0] rin, logic [ROW_W-1:0] cin);
			awaited_words = {awaited_words, correct_word(op, d, rin, cin)};
		endfunction

		function void report_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ecc_word_t got);
			ecc_word_t want;
			if (awaited_words.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
			end else begin
				want = awaited_words.pop_front();
				report_field("data_out", want.data, got.data);
				report_field("row_checks_out", want.checks, got.checks);
				report_field("col_parity_out", want.col_syn, got.col_syn);
				report_field("double_rows", want.dbl, got.dbl);
				report_field("fixed_rows", want.fixed, got.fixed);
			end
		endfunction

		function int pending();
			return awaited_words.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                opcode;
	logic [DATA_W-1:0]   data_in;
	logic [RCHK_W-1:0]   row_checks_in;
	logic [ROW_W-1:0]    col_parity_in;
	logic                done;
	logic [DATA_W-1:0]   data_out;
	logic [RCHK_W-1:0]   row_checks_out;
	logic [ROW_W-1:0]    col_parity_out;
	logic [MAX_ROWS-1:0] double_rows;
	logic [MAX_ROWS-1:0] fixed_rows;

	ecc_ledger ledger;
	int        idle_pct;

	matrix_code_double_error_corrector #(
		.DATA_ROWS(ROWS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.data_in       (data_in),
		.row_checks_in (row_checks_in),
		.col_parity_in (col_parity_in),
		.done          (done),
		.data_out      (data_out),
		.row_checks_out(row_checks_out),
		.col_parity_out(col_parity_out),
		.double_rows   (double_rows),
		.fixed_rows    (fixed_rows)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Sample both sides at the rising edge. Note the accepted transaction
	// before checking the result, so the order within the edge is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				ledger.note_transaction(op_t'(opcode), data_in, row_checks_in, col_parity_in);
			if (done)
				ledger.check_result({data_out, row_checks_out, col_parity_out,
					double_rows, fixed_rows});
		end
	end

	// Drop start for one cycle and put noise on the fields; the block must ignore it
	task automatic idle_cycle();
		@(negedge clk);
		start         = 1'b0;
		opcode        = 1'($urandom);
		data_in       = $urandom;
		row_checks_in = RCHK_W'($urandom);
		col_parity_in = ROW_W'($urandom);
	endtask

	// Idle at random per cycle, then hold the transaction until busy is low
	task automatic send_word(op_t op, logic [DATA_W-1:0] d, logic [RCHK_W-1:0] rc,
			logic [ROW_W-1:0] cp);
		bit taken;
		while ($urandom_range(99) < idle_pct)
			idle_cycle();
		@(negedge clk);
		start         = 1'b1;
		opcode        = op;
		data_in       = d;
		row_checks_in = rc;
		col_parity_in = cp;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
	endtask

	// Hold off the sender until every owed result has come, then let the pipe settle
	task automatic drain();
		while (ledger.pending() != 0)
			idle_cycle();
		repeat (TAIL) idle_cycle();
	endtask

	// Decode a clean codeword of d after flipping the given bits of {data, checks, parity}
	task automatic send_damaged(logic [DATA_W-1:0] d, logic [DATA_W-1:0] dflip,
			logic [RCHK_W-1:0] rflip, logic [ROW_W-1:0] cflip);
		ecc_word_t enc;
		enc = ledger.correct_word(OP_ENCODE, d, '0, '0);
		send_word(OP_DECODE, d ^ dflip, enc.checks ^ rflip, enc.col_syn ^ cflip);
	endtask

	task automatic directed_items();
		ecc_word_t enc;
		// Encode extremes and a couple of patterns
		send_word(OP_ENCODE, '0, '0, '0);
		send_word(OP_ENCODE, '1, '1, '1);
		send_word(OP_ENCODE, 32'hA5A5_5A5A, '0, '0);
		send_word(OP_ENCODE, 32'h8040_2001, '1, '0);
		// Clean codewords decode with zero syndromes
		send_damaged('0, '0, '0, '0);
		send_damaged('1, '0, '0, '0);
		send_damaged(32'h1234_5678, '0, '0, '0);
		// Raw extremes on every field
		send_word(OP_DECODE, '1, '1, '1);
		send_word(OP_DECODE, '0, '1, '1);
		send_word(OP_DECODE, '1, '0, '0);
		// Single errors: data bit, check bit, row parity bit, column parity bit
		send_damaged(32'hDEAD_BEEF, 32'h0000_0400, '0, '0);
		send_damaged(32'hDEAD_BEEF, '0, 20'h00040, '0);
		send_damaged(32'hDEAD_BEEF, '0, 20'h80000, '0);
		send_damaged(32'hDEAD_BEEF, '0, '0, 8'h20);
		// Double errors fixed by a column pair
		send_damaged(32'hCAFE_F00D, 32'h0000_0003, '0, '0);
		send_damaged(32'hCAFE_F00D, 32'hC000_0000, '0, '0);
		// Double errors in two rows at different columns
		send_damaged(32'h0F0F_0F0F, 32'h0000_0C03, '0, '0);
		// Same columns in every row: column syndrome cancels, no pair to flip
		send_damaged(32'h3C3C_3C3C, 32'h1212_1212, '0, '0);
		// Column syndrome with a single bit: flagged but left alone
		send_damaged(32'h7777_7777, 32'h0000_0011, '0, 8'h01);
		// Two set column bits whose patterns do not explain the syndrome
		enc = ledger.correct_word(OP_ENCODE, 32'h5555_AAAA, '0, '0);
		send_word(OP_DECODE, 32'h5555_AAAA, enc.checks ^ 20'h001E0,
			enc.col_syn ^ 8'h06);
		// All column syndrome bits set: the first matching pair wins, not the true one
		send_damaged(32'h0123_4567, 32'h0000_0090, '0, 8'hFF ^ 8'h90);
		// Two check bits of one row give a double flag with nothing to flip
		send_damaged(32'h89AB_CDEF, '0, 20'h00003, '0);
		// Walk single bits through encode
		send_word(OP_ENCODE, 32'h0000_0001, '0, '0);
		send_word(OP_ENCODE, 32'h8000_0000, '0, '0);
	endtask

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly damaged codewords with random content, the rest raw encode and decode
	task automatic random_item();
		logic [DATA_W-1:0]                    d;
		logic [ROW_W+RCHK_W+DATA_W-1:0]       flips;
		int                                   sel;
		int                                   a;
		int                                   b;
		sel   = $urandom_range(99);
		d     = pick_data();
		flips = '0;
		if (sel < 20) begin
			send_word(OP_ENCODE, d, RCHK_W'($urandom), ROW_W'($urandom));
		end else if (sel < 35) begin
			send_word(OP_DECODE, d, RCHK_W'($urandom), ROW_W'($urandom));
		end else begin
			case ($urandom_range(4))
				0: ;
				1: flips[$urandom_range(ROW_W + RCHK_W + DATA_W - 1)] = 1'b1;
				2: begin
					a = $urandom_range(ROW_W - 1);
					b = (a + 1 + $urandom_range(ROW_W - 2)) % ROW_W;
					sel = $urandom_range(ROWS - 1);
					flips[sel*ROW_W + a] = 1'b1;
					flips[sel*ROW_W + b] = 1'b1;
				end
				3: begin
					for (int r = 0; r < ROWS; r++)
						if ($urandom_range(1)) begin
							a = $urandom_range(ROW_W - 1);
							b = (a + 1 + $urandom_range(ROW_W - 2)) % ROW_W;
							flips[r*ROW_W + a] = 1'b1;
							flips[r*ROW_W + b] = 1'b1;
						end
				end
				default: begin
					repeat ($urandom_range(2, 4))
						flips[$urandom_range(ROW_W + RCHK_W + DATA_W - 1)] ^= 1'b1;
				end
			endcase
			send_damaged(d, flips[DATA_W-1:0], flips[DATA_W +: RCHK_W],
				flips[DATA_W+RCHK_W +: ROW_W]);
		end
	endtask

	initial begin
		int phase_pct [3];
		ledger        = new();
		phase_pct     = '{38, 87, 0};
		idle_pct      = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = OP_ENCODE;
		data_in       = '0;
		row_checks_in = '0;
		col_parity_in = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_pct = phase_pct[0];
		directed_items();
		drain();

		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				// Advance through stretches with no idling inside each phase
				idle_pct = ((i % 97) < 15) ? 0 : phase_pct[p];
				random_item();
				// Pause mid-phase until the pipe is empty
				if (i == N_RANDOM / 6)
					drain();
			end
			drain();
		end

		if (ledger.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Drop the run if the block stops answering
	initial begin
		#(PERIOD * 400000);
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/mcdec_pkg.sv
hdl/mcdec_lane.sv
hdl/mcdec_fix.sv
hdl/matrix_code_double_error_corrector.sv
hdl/mcdec_checker.sv
verif/testbench.sv
